// File: rtl/core/local_cse_expression_table_defines.svh
// Assertion macros for the local CSE expression table.
`ifndef LOCAL_CSE_EXPRESSION_TABLE_DEFINES_SVH
`define LOCAL_CSE_EXPRESSION_TABLE_DEFINES_SVH

`ifndef SYNTH
// Check a property on every clock edge outside reset.
`define LCSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define LCSE_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LCSE_ASSERT(lbl, prop, msg)
`define LCSE_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// File: rtl/core/lcse_pkg.sv
// Shared constants, types and hash function of the local CSE expression table.
package lcse_pkg;

  // BUCKETS is a power of two: the bucket is the low bits of the hash.
  localparam int BUCKETS     = 256;
  localparam int WAYS        = 4;
  localparam int REG_BITS    = 16;
  localparam int KIND_BITS   = 5;
  localparam int BUCKET_BITS = $clog2(BUCKETS);
  localparam int WAY_BITS    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int KEY_BITS    = KIND_BITS + 2 * REG_BITS;
  // Width of the table generation tag; a wrap of the tag forces a clearing pass.
  localparam int EPOCH_BITS  = 8;

  // Opcode kinds.
  localparam logic [KIND_BITS-1:0] OP_ADD   = 5'd0;
  localparam logic [KIND_BITS-1:0] OP_MUL   = 5'd2;
  localparam logic [KIND_BITS-1:0] OP_AND   = 5'd5;
  localparam logic [KIND_BITS-1:0] OP_OR    = 5'd6;
  localparam logic [KIND_BITS-1:0] OP_XOR   = 5'd7;
  localparam logic [KIND_BITS-1:0] OP_GE    = 5'd15;
  localparam logic [KIND_BITS-1:0] OP_CALL  = 5'd16;
  localparam logic [KIND_BITS-1:0] OP_STORE = 5'd17;

  typedef enum logic [2:0] {
    ACT_PASS     = 3'd0,
    ACT_COPY     = 3'd1,
    ACT_RECORDED = 3'd2,
    ACT_CLEARED  = 3'd3,
    ACT_NO_DEST  = 3'd4,
    ACT_FULL     = 3'd5
  } action_t;

  typedef struct packed {
    logic                   block_start;
    logic                   clear_op;
    logic                   candidate;
    logic [KEY_BITS-1:0]    key;
    logic                   dest_is_reg;
    logic [REG_BITS-1:0]    dest;
    logic [BUCKET_BITS-1:0] bucket;
  } stage_t;

  // One row of the way valid memory: valid bits and the epoch that wrote them.
  typedef struct packed {
    logic [EPOCH_BITS-1:0] epoch;
    logic [WAYS-1:0]       bits;
  } vrow_t;

  // h = (kind*31 + a)*31 + b, kept to the bucket bits (wraps mod 2^8).
  function automatic logic [BUCKET_BITS-1:0] hash_bucket(
    input logic [KIND_BITS-1:0] kind,
    input logic [REG_BITS-1:0]  a,
    input logic [REG_BITS-1:0]  b
  );
    logic [BUCKET_BITS-1:0] h;
    h = BUCKET_BITS'(kind);
    h = (h << 5) - h + BUCKET_BITS'(a);
    h = (h << 5) - h + BUCKET_BITS'(b);
    return h;
  endfunction

  function automatic logic kind_commutes(input logic [KIND_BITS-1:0] kind);
    return (kind == OP_ADD) || (kind == OP_MUL) || (kind == OP_AND) ||
           (kind == OP_OR) || (kind == OP_XOR);
  endfunction

endpackage

// File: rtl/core/local_cse_expression_table.sv
// Top level of the local CSE expression table: lookup, record and clear.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  in      | sink      | in_valid/in_stall  | block_start, op_kind, src*, dest*
//  out     | source    | out_valid/out_stall| action, copy_source_reg
//
// Steps: the accept edge reads the bucket row of the valid, key and result
// memories into registers; the evaluate stage then compares all ways, writes
// the chosen way and loads the output register once the output can take it.
// Clears: block start, call and store advance an epoch counter; a valid row
// tagged with an older epoch reads as empty, so no row is touched.
// Reset: a clearing pass over all BUCKETS (256) rows zeroes the valid memory;
// the same pass runs after the clear that wraps the epoch (every 256th clear).
// Stalls: in_stall is high while an instruction sits in the evaluate stage or
// a clearing pass runs; the stage holds while out_stall keeps a full output
// register.
`include "local_cse_expression_table_defines.svh"

module local_cse_expression_table (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          block_start,
  input  logic [lcse_pkg::KIND_BITS-1:0] op_kind,
  input  logic                          src1_is_reg,
  input  logic [lcse_pkg::REG_BITS-1:0] src1_reg,
  input  logic                          src2_is_reg,
  input  logic [lcse_pkg::REG_BITS-1:0] src2_reg,
  input  logic                          dest_is_reg,
  input  logic [lcse_pkg::REG_BITS-1:0] dest_reg,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    action,
  output logic [lcse_pkg::REG_BITS-1:0] copy_source_reg
);
  import lcse_pkg::*;

  // ---------------------------------------------------------------------
  // Input decode: canonical key and bucket of the arriving instruction.
  // ---------------------------------------------------------------------
  logic                  accept;
  logic [REG_BITS-1:0]   key_a;
  logic [REG_BITS-1:0]   key_b;
  stage_t                stg_next;

  assign accept = in_valid && !in_stall;

  always_comb begin
    // Commutative ops put the smaller source id first.
    if (kind_commutes(op_kind) && (src1_reg > src2_reg)) begin
      key_a = src2_reg;
      key_b = src1_reg;
    end else begin
      key_a = src1_reg;
      key_b = src2_reg;
    end
    stg_next.block_start = block_start;
    stg_next.clear_op    = (op_kind == OP_CALL) || (op_kind == OP_STORE);
    stg_next.candidate   = (op_kind <= OP_GE) && src1_is_reg && src2_is_reg;
    stg_next.key         = {op_kind, key_a, key_b};
    stg_next.dest_is_reg = dest_is_reg;
    stg_next.dest        = dest_reg;
    stg_next.bucket      = hash_bucket(op_kind, key_a, key_b);
  end

  // ---------------------------------------------------------------------
  // Evaluate stage: one instruction at a time.
  // ---------------------------------------------------------------------
  logic   busy;
  stage_t stg;
  logic   eval;
  logic   scrub;

  assign in_stall = busy || scrub;
  assign eval     = busy && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (eval) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg <= stg_next;
    end
  end

  // ---------------------------------------------------------------------
  // Key and result memories, one pair per way, read on accept.
  // ---------------------------------------------------------------------
  logic                   wr_en;
  logic [WAY_BITS-1:0]    wr_way;
  logic [KEY_BITS-1:0]    key_q [WAYS];
  logic [REG_BITS-1:0]    res_q [WAYS];

  for (genvar w = 0; w < WAYS; w++) begin : g_way
    logic [KEY_BITS-1:0] key_mem [BUCKETS];
    logic [REG_BITS-1:0] res_mem [BUCKETS];

    always_ff @(posedge clk) begin
      if (wr_en && (wr_way == WAY_BITS'(w))) begin
        key_mem[stg.bucket] <= stg.key;
        res_mem[stg.bucket] <= stg.dest;
      end
    end

    // No write can hit the row while the read data waits in the stage.
    always_ff @(posedge clk) begin
      if (accept) begin
        key_q[w] <= key_mem[stg_next.bucket];
        res_q[w] <= res_mem[stg_next.bucket];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Way valid memory: one row per bucket, tagged with the epoch that wrote
  // it. Block start and call/store advance the epoch instead of clearing.
  // ---------------------------------------------------------------------
  vrow_t                  valid_mem [BUCKETS];
  vrow_t                  vrow_q;
  logic [EPOCH_BITS-1:0]  epoch;
  logic [EPOCH_BITS-1:0]  epoch_next;
  logic                   clr;
  logic                   scrub_keep;
  logic [BUCKET_BITS-1:0] scrub_addr;
  logic [WAYS-1:0]        vbits;

  assign clr        = stg.block_start || stg.clear_op;
  assign epoch_next = clr ? epoch + 1'b1 : epoch;

  // Block start empties the table ahead of this instruction's lookup; a row
  // from an older epoch counts as empty.
  assign vbits = (!stg.block_start && (vrow_q.epoch == epoch)) ? vrow_q.bits : '0;

  always_ff @(posedge clk) begin
    if (accept) begin
      vrow_q <= valid_mem[stg_next.bucket];
    end
  end

  // Keep the row the wrapping instruction just recorded; zero every other.
  always_ff @(posedge clk) begin
    if (scrub) begin
      if (!(scrub_keep && (scrub_addr == stg.bucket))) begin
        valid_mem[scrub_addr] <= '0;
      end
    end else if (wr_en) begin
      valid_mem[stg.bucket] <= {epoch_next, vbits | (WAYS'(1) << wr_way)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      epoch      <= '0;
      scrub      <= 1'b1;
      scrub_keep <= 1'b0;
      scrub_addr <= '0;
    end else if (scrub) begin
      scrub_addr <= scrub_addr + 1'b1;
      if (scrub_addr == BUCKET_BITS'(BUCKETS - 1)) begin
        scrub <= 1'b0;
      end
    end else if (eval) begin
      epoch <= epoch_next;
      // The epoch wraps: run a pass so stale rows cannot match again.
      if (clr && (epoch == '1)) begin
        scrub      <= 1'b1;
        scrub_keep <= wr_en;
        scrub_addr <= '0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Compare and choose: first hit way, else lowest free way.
  // ---------------------------------------------------------------------
  logic                hit;
  logic [WAY_BITS-1:0] hit_way;
  logic                has_free;
  logic [WAY_BITS-1:0] free_way;
  action_t             act;

  always_comb begin
    hit      = 1'b0;
    hit_way  = '0;
    has_free = 1'b0;
    free_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit && vbits[w] && (key_q[w] == stg.key)) begin
        hit     = 1'b1;
        hit_way = WAY_BITS'(w);
      end
      if (!has_free && !vbits[w]) begin
        has_free = 1'b1;
        free_way = WAY_BITS'(w);
      end
    end
  end

  always_comb begin
    act    = ACT_PASS;
    wr_en  = 1'b0;
    wr_way = free_way;
    priority if (stg.clear_op) begin
      act = ACT_CLEARED;
    end else if (stg.candidate) begin
      priority if (hit) begin
        act = ACT_COPY;
      end else if (!stg.dest_is_reg) begin
        act = ACT_NO_DEST;
      end else if (has_free) begin
        act   = ACT_RECORDED;
        wr_en = eval;
      end else begin
        act = ACT_FULL;
      end
    end else begin
      act = ACT_PASS;
    end
  end

  // ---------------------------------------------------------------------
  // Output register: holds the result until its transfer.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (eval) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eval) begin
      action          <= act;
      copy_source_reg <= (act == ACT_COPY) ? res_q[hit_way] : '0;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  `LCSE_ASSERT(a_write_in_eval, wr_en |-> eval && !hit, "table write outside evaluate or on hit")
  `LCSE_ASSERT(a_accept_busy, accept |=> busy && !accept, "accepted transfer not held in stage")
  `LCSE_ASSERT(a_eval_out, eval |=> out_valid && !busy, "evaluated item did not reach output")
  `LCSE_ASSERT(a_clear_no_hit, (eval && stg.block_start) |-> !hit, "hit on a cleared table")
  `LCSE_ASSERT(a_scrub_no_accept, scrub |-> !accept, "transfer accepted during clearing pass")
  `LCSE_ASSERT_RST(a_reset_idle, rst |=> !busy && !out_valid, "control not idle after reset")

endmodule
